### rtl/core/tdfe_pkg.sv
// ----------------------------------------------------------------------------
// tdfe_pkg
// Shared types and constants of the delta telemetry frame encoder.
// ----------------------------------------------------------------------------
package tdfe_pkg;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_VAR    = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_SIG    = 2'd2,
    KIND_SIZE   = 2'd3
  } kind_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME    = 2'd1;

  localparam logic [12:0] MAX_FRAME_RST = 13'd256;
  localparam logic [12:0] MAX_FRAME_LO  = 13'd3;
  localparam logic [12:0] MAX_FRAME_HI  = 13'd4096;

  // ts / 10 == (ts * DIV10_MUL) >> 35 for every 32-bit ts
  localparam logic [31:0] DIV10_MUL = 32'hCCCCCCCD;
  localparam int          DIV10_SH  = 35;
  // ts % 625 == 0 iff (ts * inverse of 625, modulo 2^32) <= (2^32 - 1) / 625
  localparam logic [31:0] INV25      = 32'hC28F5C29;
  localparam logic [31:0] INV625     = 32'(64'(INV25) * 64'(INV25));
  localparam logic [31:0] DIV625_LIM = 32'(64'h0000_0000_FFFF_FFFF / 64'd625);

  localparam logic [11:0] OFFSET_SAT = 12'hFFF;
  localparam int          SIG_PEND_W = 6;

  localparam int RES_DEPTH = 4;
  localparam int RES_AW    = $clog2(RES_DEPTH);
  localparam int RES_CW    = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_ms;
    logic        high_detail;
    logic [63:0] var_bytes;
    logic [3:0]  var_len;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] offset;
    logic [3:0]  nbytes;
    logic [63:0] payload;
    logic [12:0] frame_size;
  } out_item_t;

  // results of one accepted item, packed from slot 0
  typedef struct packed {
    logic vld0;
    logic vld1;
  } res_push_t;

endpackage

### rtl/core/tdfe_snap_ram.sv
// ----------------------------------------------------------------------------
// tdfe_snap_ram
// Snapshot memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tdfe_snap_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/tdfe_res_fifo.sv
// ----------------------------------------------------------------------------
// tdfe_res_fifo
// Result queue: takes up to two items a cycle, hands out one.
// ----------------------------------------------------------------------------
module tdfe_res_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  tdfe_pkg::res_push_t push,
  input  tdfe_pkg::out_item_t din0,
  input  tdfe_pkg::out_item_t din1,
  output logic                out_valid,
  input  logic                out_stall,
  output tdfe_pkg::out_item_t dout,
  output logic                almost_full
);
  import tdfe_pkg::*;

  out_item_t         mem_r [RES_DEPTH];
  logic [RES_AW-1:0] head_r;
  logic [RES_AW-1:0] tail_r;
  logic [RES_CW-1:0] count_r;
  logic [RES_AW-1:0] tail1;
  logic              pop;
  logic [RES_CW-1:0] count_nxt;
  logic [RES_AW-1:0] tail_nxt;
  logic [RES_AW-1:0] head_nxt;

  assign out_valid   = (count_r != '0);
  assign dout        = mem_r[head_r];
  assign almost_full = (count_r > RES_CW'(RES_DEPTH - 2));
  assign pop         = out_valid & ~out_stall;
  assign tail1       = tail_r + RES_AW'(push.vld0);

  always_comb begin
    count_nxt = count_r + RES_CW'(push.vld0) + RES_CW'(push.vld1) - RES_CW'(pop);
    tail_nxt  = tail1 + RES_AW'(push.vld1);
    head_nxt  = head_r + RES_AW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld0) begin
      mem_r[tail_r] <= din0;
    end
    if (push.vld1) begin
      mem_r[tail1] <= din1;
    end
  end

endmodule

### rtl/core/tdfe_core.sv
// ----------------------------------------------------------------------------
// tdfe_core
// Frame state, change detection and result generation, one item a cycle.
// ----------------------------------------------------------------------------
module tdfe_core #(
  parameter int NUM_VARS      = 256,
  parameter int MAX_VAR_BYTES = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tdfe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tdfe_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_accept,
  input  tdfe_pkg::in_item_t                   in_item,
  input  logic [8*MAX_VAR_BYTES-1:0]           snap_rdata,
  output logic                                 snap_we,
  output logic [$clog2(NUM_VARS)-1:0]          snap_waddr,
  output logic [8*MAX_VAR_BYTES-1:0]           snap_wdata,
  output logic [$clog2(NUM_VARS)-1:0]          snap_raddr,
  output tdfe_pkg::res_push_t                  res_push,
  output tdfe_pkg::out_item_t                  res0,
  output tdfe_pkg::out_item_t                  res1
);
  import tdfe_pkg::*;

  localparam int IW = $clog2(NUM_VARS);
  localparam int SW = 8 * MAX_VAR_BYTES;

  // state registers
  logic [NUM_VARS-1:0]   resend_r,      resend_nxt;
  logic                  resend_all_r,  resend_all_nxt;
  logic                  last_hd_r,     last_hd_nxt;
  logic [31:0]           ts_r,          ts_nxt;
  logic [31:0]           last_time_r,   last_time_nxt;
  logic [IW-1:0]         cnt_r,         cnt_nxt;
  logic [12:0]           size_r,        size_nxt;
  logic [SIG_PEND_W-1:0] sig_pend_r,    sig_pend_nxt;
  logic [7:0]            sig_bits_r,    sig_bits_nxt;
  logic [11:0]           sig_off_r,     sig_off_nxt;
  logic [11:0]           wr_off_r,      wr_off_nxt;
  logic                  stopped_r,     stopped_nxt;
  logic [15:0]           period_r,      period_nxt;
  logic [12:0]           max_r,         max_nxt;

  // datapath
  logic [3:0]  len_c;
  logic [63:0] mask;
  logic [63:0] val;
  logic        send;
  logic [12:0] sum;
  logic        ovf;
  logic        last_var;
  logic        grp_end;
  logic [7:0]  sig_bits_upd;
  logic [11:0] wr_off_upd;
  logic        sig_ok;
  logic [63:0] hdr_prod;
  logic [14:0] ts10;
  logic [31:0] mod_prod;
  logic        ts_div10000;
  logic [31:0] ts_step;
  logic [12:0] cfg_max;
  out_item_t   res_a, res_b;
  logic        a_v,   b_v;

  function automatic logic [11:0] sat_add(input logic [11:0] a, input logic [3:0] b);
    logic [12:0] s;
    s = {1'b0, a} + 13'(b);
    sat_add = s[12] ? OFFSET_SAT : s[11:0];
  endfunction

  function automatic out_item_t sig_item(input logic [11:0] off, input logic [7:0] bits);
    out_item_t r;
    r.kind       = KIND_SIG;
    r.offset     = off;
    r.nbytes     = 4'd1;
    r.payload    = {56'b0, bits};
    r.frame_size = '0;
    sig_item     = r;
  endfunction

  // --- variable compare ---
  assign len_c = (in_item.var_len > 4'(MAX_VAR_BYTES)) ? 4'(MAX_VAR_BYTES) : in_item.var_len;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[8*b +: 8] = {8{4'(b) < len_c}};
    end
  end

  assign val      = in_item.var_bytes & mask;
  assign send     = resend_r[cnt_r] | ((snap_rdata & mask[SW-1:0]) != val[SW-1:0]);
  assign sum      = size_r + 13'(len_c) + 13'(sig_pend_r);
  assign ovf      = send & (sum >= max_r);
  assign last_var = (cnt_r == IW'(NUM_VARS - 1));
  assign grp_end  = (cnt_r[2:0] == 3'd7);
  assign sig_ok   = ({1'b0, sig_off_r} < max_r);

  assign sig_bits_upd = send ? (sig_bits_r | (8'd1 << cnt_r[2:0])) : sig_bits_r;
  assign wr_off_upd   = send ? sat_add(wr_off_r, len_c) : wr_off_r;

  // --- timestamp arithmetic ---
  assign hdr_prod    = 64'(ts_r) * 64'(DIV10_MUL);
  assign ts10        = hdr_prod[DIV10_SH +: 15];
  assign mod_prod    = ts_r * INV625;
  assign ts_div10000 = (ts_r[3:0] == 4'd0) && (mod_prod <= DIV625_LIM);
  assign ts_step     = (period_r != 16'd0) ? 32'(period_r) : (in_item.now_ms - last_time_r);

  assign cfg_max = (cfg_data[12:0] < MAX_FRAME_LO) ? MAX_FRAME_LO :
                   (cfg_data[12:0] > MAX_FRAME_HI) ? MAX_FRAME_HI : cfg_data[12:0];

  // --- snapshot memory ---
  assign snap_waddr = cnt_r;
  assign snap_wdata = (snap_rdata & ~mask[SW-1:0]) | val[SW-1:0];
  assign snap_raddr = cnt_nxt;

  always_comb begin
    resend_nxt     = resend_r;
    resend_all_nxt = resend_all_r;
    last_hd_nxt    = last_hd_r;
    ts_nxt         = ts_r;
    last_time_nxt  = last_time_r;
    cnt_nxt        = cnt_r;
    size_nxt       = size_r;
    sig_pend_nxt   = sig_pend_r;
    sig_bits_nxt   = sig_bits_r;
    sig_off_nxt    = sig_off_r;
    wr_off_nxt     = wr_off_r;
    stopped_nxt    = stopped_r;
    period_nxt     = period_r;
    max_nxt        = max_r;
    snap_we        = 1'b0;
    res_a          = '0;
    res_b          = '0;
    a_v            = 1'b0;
    b_v            = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_PERIOD: period_nxt = cfg_data;
        CFG_MAX_FRAME:    max_nxt    = cfg_max;
        default:          ;
      endcase
    end

    if (in_accept) begin
      case (in_item.cmd)
        CMD_START: begin
          // a detail change schedules a full resend, applied right here
          if (resend_all_r || (last_hd_r != in_item.high_detail)) begin
            resend_nxt = '1;
          end
          resend_all_nxt = 1'b0;
          last_hd_nxt    = in_item.high_detail;
          res_a.kind     = KIND_HEADER;
          res_a.offset   = '0;
          res_a.nbytes   = 4'd2;
          res_a.payload  = {48'b0, in_item.high_detail, ts10[14:8], ts10[7:0]};
          a_v            = 1'b1;
          cnt_nxt        = '0;
          size_nxt       = 13'd2;
          sig_pend_nxt   = SIG_PEND_W'(1);
          sig_bits_nxt   = '0;
          sig_off_nxt    = 12'd2;
          wr_off_nxt     = 12'd3;
          stopped_nxt    = 1'b0;
        end
        CMD_VAR: begin
          if (!stopped_r) begin
            if (ovf) begin
              // keep the variable for the next frame, close the group, stop
              resend_nxt[cnt_r] = 1'b1;
              res_b             = sig_item(sig_off_r, sig_bits_r);
              b_v               = sig_ok;
              stopped_nxt       = 1'b1;
            end else begin
              if (send) begin
                resend_nxt[cnt_r] = 1'b0;
                snap_we           = 1'b1;
                res_a.kind        = KIND_DATA;
                res_a.offset      = wr_off_r;
                res_a.nbytes      = len_c;
                res_a.payload     = val;
                a_v               = 1'b1;
                size_nxt          = sum;
                sig_pend_nxt      = '0;
              end
              sig_bits_nxt = sig_bits_upd;
              wr_off_nxt   = wr_off_upd;
              if (grp_end) begin
                res_b        = sig_item(sig_off_r, sig_bits_upd);
                b_v          = sig_ok;
                sig_bits_nxt = '0;
                sig_pend_nxt = (send ? SIG_PEND_W'(0) : sig_pend_r) + SIG_PEND_W'(1);
                sig_off_nxt  = wr_off_upd;
                wr_off_nxt   = sat_add(wr_off_upd, 4'd1);
                if (last_var) begin
                  stopped_nxt = 1'b1;
                end
              end else if (last_var) begin
                res_b       = sig_item(sig_off_r, sig_bits_upd);
                b_v         = sig_ok;
                stopped_nxt = 1'b1;
              end
              cnt_nxt = cnt_r + IW'(1);
            end
          end
        end
        CMD_FINISH: begin
          res_a            = sig_item(sig_off_r, sig_bits_r);
          a_v              = ~stopped_r & sig_ok;
          stopped_nxt      = 1'b1;
          res_b.kind       = KIND_SIZE;
          res_b.offset     = '0;
          res_b.nbytes     = '0;
          res_b.payload    = '0;
          res_b.frame_size = size_r;
          b_v              = 1'b1;
          if (ts_div10000) begin
            resend_all_nxt = 1'b1;
          end
          ts_nxt        = ts_r + ts_step;
          last_time_nxt = in_item.now_ms;
        end
        default: ;
      endcase
    end

    // pack results from slot 0
    if (a_v) begin
      res0         = res_a;
      res1         = res_b;
      res_push     = '{vld0: 1'b1, vld1: b_v};
    end else begin
      res0         = res_b;
      res1         = res_b;
      res_push     = '{vld0: b_v, vld1: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resend_r     <= '1;
      resend_all_r <= 1'b1;
      last_hd_r    <= 1'b0;
      ts_r         <= '0;
      last_time_r  <= '0;
      cnt_r        <= '0;
      size_r       <= 13'd2;
      sig_pend_r   <= SIG_PEND_W'(1);
      sig_bits_r   <= '0;
      sig_off_r    <= 12'd2;
      wr_off_r     <= 12'd3;
      stopped_r    <= 1'b0;
      period_r     <= '0;
      max_r        <= MAX_FRAME_RST;
    end else begin
      resend_r     <= resend_nxt;
      resend_all_r <= resend_all_nxt;
      last_hd_r    <= last_hd_nxt;
      ts_r         <= ts_nxt;
      last_time_r  <= last_time_nxt;
      cnt_r        <= cnt_nxt;
      size_r       <= size_nxt;
      sig_pend_r   <= sig_pend_nxt;
      sig_bits_r   <= sig_bits_nxt;
      sig_off_r    <= sig_off_nxt;
      wr_off_r     <= wr_off_nxt;
      stopped_r    <= stopped_nxt;
      period_r     <= period_nxt;
      max_r        <= max_nxt;
    end
  end

endmodule

### rtl/core/telemetry_delta_frame_encoder.sv
// ----------------------------------------------------------------------------
// telemetry_delta_frame_encoder
// Builds delta telemetry frames: header, changed variables, signature bytes
// and the frame size, as a stream of byte-write items.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | item
//   --------+-----------+-----------------------+------------------------------
//   in_     | input     | in_valid / in_stall   | in_item (tdfe_pkg::in_item_t)
//   out_    | output    | out_valid / out_stall | out_item (tdfe_pkg::out_item_t)
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item is taken per cycle while in_stall is low. Its state update happens
// at the accepting edge; its results, up to two, enter a four-entry result
// queue, and the first is offered on the cycle after acceptance if the
// queue was empty. in_stall rises with fewer than two free entries; with one
// result per item drained each cycle the block keeps up one item per cycle.
// The snapshot memory is read one entry ahead, at the next variable index,
// so its registered read data is ready when the variable arrives.
// Reset is synchronous; it sets all resend flags at once, so the snapshot
// memory needs no clearing pass; its stale contents never block the first send.
// Configuration is always ready (cfg_ready is tied high).
// ----------------------------------------------------------------------------
module telemetry_delta_frame_encoder #(
  parameter int NUM_VARS      = 256,
  parameter int MAX_VAR_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tdfe_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tdfe_pkg::out_item_t               out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tdfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tdfe_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tdfe_pkg::*;

  localparam int IW = $clog2(NUM_VARS);
  localparam int SW = 8 * MAX_VAR_BYTES;

  logic          in_accept;
  logic          cfg_we;
  logic          almost_full;
  logic          snap_we;
  logic [IW-1:0] snap_waddr;
  logic [IW-1:0] snap_raddr;
  logic [SW-1:0] snap_wdata;
  logic [SW-1:0] snap_rdata;
  res_push_t     res_push;
  out_item_t     res0;
  out_item_t     res1;

  // hold the input while the result queue cannot take two more items
  assign in_stall  = almost_full;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  tdfe_core #(
    .NUM_VARS      (NUM_VARS),
    .MAX_VAR_BYTES (MAX_VAR_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_accept  (in_accept),
    .in_item    (in_item),
    .snap_rdata (snap_rdata),
    .snap_we    (snap_we),
    .snap_waddr (snap_waddr),
    .snap_wdata (snap_wdata),
    .snap_raddr (snap_raddr),
    .res_push   (res_push),
    .res0       (res0),
    .res1       (res1)
  );

  tdfe_snap_ram #(
    .DEPTH (NUM_VARS),
    .AW    (IW),
    .DW    (SW)
  ) u_snap_ram (
    .clk   (clk),
    .we    (snap_we),
    .waddr (snap_waddr),
    .wdata (snap_wdata),
    .raddr (snap_raddr),
    .rdata (snap_rdata)
  );

  tdfe_res_fifo u_res_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (res_push),
    .din0        (res0),
    .din1        (res1),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .dout        (out_item),
    .almost_full (almost_full)
  );

endmodule

### verif/telemetry_delta_frame_encoder_test.sv
// ----------------------------------------------------------------------------
// telemetry_delta_frame_encoder_test
// Self-checking bench for the delta telemetry frame encoder. A clocked driver
// feeds frame items from a queue. A clocked monitor compares every byte-write
// result with the predicted one. The bench runs a directed opening, then
// random frames under several frame period and frame size settings.
// ----------------------------------------------------------------------------
module telemetry_delta_frame_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tdfe_pkg::*;

  localparam int MAX_LEN     = 8;
  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int REPORT_CAP  = 200;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  telemetry_delta_frame_encoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Encoder prediction: own copy of the frame state and the two registers
  // --------------------------------------------------------------------------
  logic [63:0] snap_mem [256];
  bit          resend_flag [256];
  bit          resend_all   = 1'b1;
  bit          last_hd      = 1'b0;
  logic [31:0] ts_ms        = '0;
  logic [31:0] last_now     = '0;
  logic [7:0]  var_idx      = '0;
  int unsigned data_bytes   = 0;
  int unsigned sig_bytes    = 0;
  int unsigned sig_open     = 1;
  logic [7:0]  sig_mask     = '0;
  int unsigned sig_at       = 2;
  int unsigned wr_at        = 3;
  bit          stopped      = 1'b0;
  logic [15:0] period_cfg   = '0;
  logic [12:0] frame_cap    = MAX_FRAME_RST;

  out_item_t   expected_writes [$];
  in_item_t    items_to_send [$];
  int unsigned queued_count = 0;
  int unsigned sent_count   = 0;
  int          mismatches   = 0;

  function automatic int unsigned frame_limit();
    if (frame_cap < MAX_FRAME_LO) return MAX_FRAME_LO;
    if (frame_cap > MAX_FRAME_HI) return MAX_FRAME_HI;
    return frame_cap;
  endfunction

  function automatic int unsigned clamp_offset(int unsigned v);
    return (v > 4095) ? 4095 : v;
  endfunction

  function automatic void push_write(kind_t k, int unsigned off, int unsigned nb,
                                     logic [63:0] pay, int unsigned size);
    out_item_t w;
    w.kind       = k;
    w.offset     = 12'(off);
    w.nbytes     = 4'(nb);
    w.payload    = pay;
    w.frame_size = 13'(size);
    expected_writes.push_back(w);
  endfunction

  // Signature bytes that land outside the frame are dropped.
  function automatic void push_signature();
    if (sig_at < frame_limit())
      push_write(KIND_SIG, sig_at, 1, {56'd0, sig_mask}, 0);
  endfunction

  function automatic void encode_item(in_item_t it);
    int unsigned len;
    logic [63:0] mask;
    logic [63:0] val;
    logic [7:0]  idx;
    logic [14:0] ts;
    bit          send;
    case (it.cmd)
      CMD_START: begin
        ts = 15'(ts_ms / 10);
        if (last_hd != it.high_detail) begin
          last_hd    = it.high_detail;
          resend_all = 1'b1;
        end
        push_write(KIND_HEADER, 0, 2, {48'd0, it.high_detail, ts[14:8], ts[7:0]}, 0);
        if (resend_all) begin
          foreach (resend_flag[i]) resend_flag[i] = 1'b1;
          resend_all = 1'b0;
        end
        var_idx    = '0;
        data_bytes = 0;
        sig_bytes  = 0;
        sig_open   = 1;
        sig_mask   = '0;
        sig_at     = 2;
        wr_at      = 3;
        stopped    = 1'b0;
      end
      CMD_VAR: begin
        if (!stopped) begin
          idx  = var_idx;
          len  = (it.var_len > MAX_LEN) ? MAX_LEN : it.var_len;
          mask = (len >= 8) ? '1 : ((64'd1 << (len * 8)) - 64'd1);
          val  = it.var_bytes & mask;
          if (resend_flag[idx]) begin
            resend_flag[idx] = 1'b0;
            send = 1'b1;
          end else begin
            send = ((snap_mem[idx] & mask) != val);
          end
          if (send && (data_bytes + sig_bytes + 2 + len + sig_open >= frame_limit())) begin
            // overflow: keep the variable pending and close the frame
            resend_flag[idx] = 1'b1;
            push_signature();
            stopped = 1'b1;
          end else begin
            if (send) begin
              snap_mem[idx] = (snap_mem[idx] & ~mask) | val;
              push_write(KIND_DATA, wr_at, len, val, 0);
              data_bytes += len;
              wr_at       = clamp_offset(wr_at + len);
              sig_bytes  += sig_open;
              sig_open    = 0;
              sig_mask   |= 8'd1 << idx[2:0];
            end
            // close the group of eight; the last variable also ends the frame
            if (idx[2:0] == 3'd7) begin
              push_signature();
              sig_mask  = '0;
              sig_open += 1;
              sig_at    = wr_at;
              wr_at     = clamp_offset(wr_at + 1);
              if (idx == 8'd255) stopped = 1'b1;
            end
            var_idx = var_idx + 8'd1;
          end
        end
      end
      CMD_FINISH: begin
        if (!stopped) push_signature();
        stopped = 1'b1;
        push_write(KIND_SIZE, 0, 0, '0, data_bytes + sig_bytes + 2);
        if ((ts_ms % 10000) == 0) resend_all = 1'b1;
        ts_ms    = ts_ms + ((period_cfg != 0) ? 32'(period_cfg) : (it.now_ms - last_now));
        last_now = it.now_ms;
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Idle draws: a random idle gap for each item, with occasional stretches of no idling
  // --------------------------------------------------------------------------
  function automatic int next_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // --------------------------------------------------------------------------
  // Item driver: hold a stalled item, predict on each accepted one, then
  // advance to the next queued item after its idle gap.
  // --------------------------------------------------------------------------
  int in_gap   = 0;
  int in_quiet = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        encode_item(in_item);
        sent_count++;
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (items_to_send.size() != 0) begin
        in_item  <= items_to_send.pop_front();
        in_valid <= 1'b1;
        in_gap    = next_wait(in_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each accepted write with the oldest prediction
  // --------------------------------------------------------------------------
  int out_hold  = 0;
  int out_quiet = 0;

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      // keep a broken build from flooding the log
      if (mismatches <= REPORT_CAP)
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $error("unexpected result: kind %0d offset %0d nbytes %0d",
                 out_item.kind, out_item.offset, out_item.nbytes);
      end else begin
        want = expected_writes.pop_front();
        check_field("kind",       want.kind,       out_item.kind);
        check_field("offset",     want.offset,     out_item.offset);
        check_field("nbytes",     want.nbytes,     out_item.nbytes);
        check_field("payload",    want.payload,    out_item.payload);
        check_field("frame_size", want.frame_size, out_item.frame_size);
      end
      out_hold = next_wait(out_quiet);
    end else if (out_hold > 0) begin
      out_hold--;
    end
    out_stall <= (out_hold > 0);
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no handshake completes for too long
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** telemetry_delta_frame_encoder: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus. Packed sizes stay fixed per variable and detail mode, so the
  // encoder never compares snapshot bytes that were not written since the
  // last full resend.
  // --------------------------------------------------------------------------
  logic [3:0]  var_width [2][256];
  logic [63:0] gen_val [256];
  bit          gen_mode = 1'b0;
  int          gen_idx  = 0;
  logic [31:0] gen_now  = '0;

  function automatic void queue_item(cmd_t cmd, logic [31:0] now, logic hd,
                                     logic [63:0] bytes, logic [3:0] len);
    in_item_t it;
    it.cmd         = cmd;
    it.now_ms      = now;
    it.high_detail = hd;
    it.var_bytes   = bytes;
    it.var_len     = len;
    items_to_send.push_back(it);
    queued_count++;
    if (cmd == CMD_START) begin
      gen_mode = hd;
      gen_idx  = 0;
    end else if (cmd == CMD_VAR) begin
      gen_idx++;
    end
  endfunction

  function automatic void queue_start(bit hd);
    queue_item(CMD_START, $urandom, hd, {$urandom, $urandom}, 4'($urandom_range(1, 8)));
  endfunction

  function automatic void queue_finish(logic [31:0] now);
    gen_now = now;
    queue_item(CMD_FINISH, now, 1'($urandom_range(0, 1)), {$urandom, $urandom},
               4'($urandom_range(1, 8)));
  endfunction

  // Pick the next finish time: random jumps, exact 10 s steps, repeats, and
  // small steps.
  function automatic logic [31:0] advance_clock();
    case ($urandom_range(0, 4))
      0:       return $urandom;
      1:       return gen_now + 32'd10000;
      2:       return gen_now;
      default: return gen_now + 32'($urandom_range(1, 500));
    endcase
  endfunction

  // Next variable of the frame: keep its last bytes, or change them with the
  // given chance. Bytes above the packed length carry junk.
  function automatic void queue_var(int change_pct);
    logic [7:0]  idx;
    int unsigned len;
    logic [63:0] mask;
    logic [63:0] val;
    idx  = 8'(gen_idx);
    len  = (gen_idx < 256) ? var_width[gen_mode][idx] : $urandom_range(1, 8);
    mask = (len >= 8) ? '1 : ((64'd1 << (len * 8)) - 64'd1);
    val  = gen_val[idx];
    if ($urandom_range(0, 99) < change_pct) begin
      case ($urandom_range(0, 3))
        0:       val = '0;
        1:       val = '1;
        2:       val = val ^ (64'hFF << (8 * $urandom_range(0, len - 1)));
        default: val = {$urandom, $urandom};
      endcase
    end
    gen_val[idx] = val;
    queue_item(CMD_VAR, $urandom, 1'($urandom_range(0, 1)),
               (val & mask) | ({$urandom, $urandom} & ~mask), 4'(len));
  endfunction

  function automatic void queue_frame(int nvars, bit hd, int change_pct, bit close);
    queue_start(hd);
    repeat (nvars) queue_var(change_pct);
    if (close) queue_finish(advance_clock());
  endfunction

  // Mostly well-formed frames, some full-length ones, some left open, and a
  // little noise: lone commands in any order and ignored items.
  task automatic queue_random(int n_items);
    int unsigned stop_at;
    int          roll;
    int          pct;
    bit          hd;
    stop_at = queued_count + n_items;
    while (queued_count < stop_at) begin
      roll = $urandom_range(0, 99);
      hd   = ($urandom_range(0, 9) == 0) ? !gen_mode : gen_mode;
      case ($urandom_range(0, 3))
        0:       pct = 0;
        1:       pct = 5;
        2:       pct = 30;
        default: pct = 100;
      endcase
      if (roll < 8) begin
        queue_frame(256 + $urandom_range(0, 2), hd, pct, 1'b1);
      end else if (roll < 88) begin
        queue_frame($urandom_range(0, 40), hd, pct, 1'b1);
      end else if (roll < 93) begin
        queue_frame($urandom_range(0, 20), hd, pct, 1'b0);
      end else begin
        case (cmd_t'($urandom_range(0, 3)))
          CMD_START:  queue_start(1'($urandom_range(0, 1)));
          CMD_VAR:    queue_var(50);
          CMD_FINISH: queue_finish(advance_clock());
          default:    queue_item(CMD_NONE, $urandom, 1'($urandom_range(0, 1)),
                                 {$urandom, $urandom}, 4'($urandom_range(1, 8)));
        endcase
      end
    end
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_FRAME_PERIOD) period_cfg = value;
    else if (idx == CFG_MAX_FRAME) frame_cap = value[12:0];
  endtask

  // Wait until every item is taken and every result is in, then let the
  // block settle.
  task automatic wait_idle();
    while (sent_count != queued_count || expected_writes.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [15:0] period;
    logic [15:0] cap;

    for (int i = 0; i < 256; i++) begin
      resend_flag[i] = 1'b1;
      snap_mem[i]    = '0;
      gen_val[i]     = '0;
      var_width[0][i] = 4'($urandom_range(1, 8));
      var_width[1][i] = 4'($urandom_range(1, 8));
    end
    // pin the widths that the opening items rely on
    var_width[0][0] = 4'd8;
    var_width[0][1] = 4'd1;
    var_width[1][0] = 4'd1;
    var_width[1][1] = 4'd8;

    // Items ahead of the first start run on the reset frame state.
    gen_val[0] = '1;
    queue_var(0);
    queue_finish(32'd10000);
    queue_var(100);                       // frame stopped: no result
    queue_item(CMD_NONE, '1, 1'b1, '1, 4'd8);
    // First start: full resend pending since reset.
    queue_start(1'b0);
    queue_var(0);                         // all-ones, eight bytes
    gen_val[1] = '0;
    queue_var(0);                         // zero, one byte
    repeat (6) queue_var(100);            // closes the first signature group
    queue_finish('1);                     // timestamp on a 10 s boundary
    queue_finish('1);                     // repeated finish, no elapsed time
    // Mode change forces a full resend.
    queue_start(1'b1);
    repeat (3) queue_var(100);
    queue_finish(32'd0);                  // elapsed time wraps
    // Same mode, same bytes: nothing but header, signature and size.
    queue_start(1'b1);
    repeat (3) queue_var(0);
    queue_finish(advance_clock());

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0:       begin period = 16'd1000;  cap = 16'd4096; end
        1:       begin period = 16'd0;     cap = 16'd3;    end
        2:       begin period = 16'd65535; cap = 16'd60;   end
        3:       begin period = 16'd10;    cap = 16'd300;  end
        4:       begin period = 16'd0;     cap = 16'd4096; end
        5:       begin
          period = 16'($urandom_range(0, 65535));
          cap    = 16'($urandom_range(3, 4096));
        end
        6:       begin period = 16'd2500;  cap = 16'd25;   end
        default: begin period = 16'd0;     cap = 16'd256;  end
      endcase
      cfg_write(CFG_FRAME_PERIOD, period);
      cfg_write(CFG_MAX_FRAME, cap);
      @(negedge clk);
      queue_random(PHASE_ITEMS);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("** telemetry_delta_frame_encoder: PASSED **");
    end else begin
      $display("** telemetry_delta_frame_encoder: FAILED **");
    end
    $finish;
  end

endmodule
